>>> rtl/owss_pkg.sv
package owss_pkg;

  localparam int COL_W      = 12;
  localparam int IN_W_W     = 13;
  localparam int OUT_W_W    = 13;
  localparam int OVL_W      = 12;
  localparam int NOUT_W     = 4;
  localparam int PORT_W     = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  // signed width that holds k*stride + out_width for every legal setting
  localparam int POS_W      = 18;

  localparam int COLUMN_LIMIT    = 4096;
  localparam int QUEUE_DEPTH     = 4;
  localparam int DEF_DATA_WIDTH  = 32;
  localparam int DEF_MAX_OUTPUTS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 8'd3;

  localparam logic [IN_W_W-1:0]  RST_IN_WIDTH    = 13'd64;
  localparam logic [OUT_W_W-1:0] RST_OUT_WIDTH   = 13'd16;
  localparam logic [OVL_W-1:0]   RST_OVERLAP     = 12'd0;
  localparam logic [NOUT_W-1:0]  RST_NUM_OUTPUTS = 4'd4;

  // routing of one element: up to two windows, lower port first
  typedef struct packed {
    logic [PORT_W-1:0] port_a;
    logic              end_a;
    logic [PORT_W-1:0] port_b;
    logic              end_b;
    logic              two;
  } route_t;

endpackage

>>> rtl/owss_if.sv
interface owss_in_if import owss_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, data_in, input ready);
  modport sink   (input valid, data_in, output ready);
endinterface

interface owss_out_if import owss_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [PORT_W-1:0]     port;
  logic [DATA_WIDTH-1:0] data_out;
  logic                  window_end;
  logic                  last;

  modport source (output valid, port, data_out, window_end, last, input ready);
  modport sink   (input valid, port, data_out, window_end, last, output ready);
endinterface

interface owss_cfg_if import owss_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/owss_fifo.sv
module owss_fifo import owss_pkg::*; #(
  parameter int WIDTH = DEF_DATA_WIDTH + $bits(route_t),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

>>> rtl/owss_front.sv
module owss_front import owss_pkg::*; #(
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  owss_in_if.sink                               in_s,
  owss_cfg_if.sink                              cfg_s,
  output logic                                  push,
  output logic [DATA_WIDTH+$bits(route_t)-1:0]  push_data,
  input  logic                                  full
);

  logic [IN_W_W-1:0]  in_width_r;
  logic [OUT_W_W-1:0] out_width_r;
  logic [OVL_W-1:0]   overlap_r;
  logic [NOUT_W-1:0]  num_outputs_r;
  logic [COL_W-1:0]   column_r, column_nxt;

  logic                    accept;
  logic [IN_W_W-1:0]       width_eff;
  logic [NOUT_W-1:0]       count_eff;
  logic [IN_W_W:0]         col_inc;
  logic signed [POS_W-1:0] stride;
  logic signed [POS_W-1:0] owid;
  logic signed [POS_W-1:0] col_s;
  logic [MAX_OUTPUTS-1:0]  covered;
  logic [MAX_OUTPUTS-1:0]  at_end;
  route_t                  route;
  logic                    got_a;

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = !full;
  assign accept      = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r    <= RST_IN_WIDTH;
      out_width_r   <= RST_OUT_WIDTH;
      overlap_r     <= RST_OVERLAP;
      num_outputs_r <= RST_NUM_OUTPUTS;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_IN_WIDTH:    in_width_r    <= cfg_s.data[IN_W_W-1:0];
        REG_OUT_WIDTH:   out_width_r   <= cfg_s.data[OUT_W_W-1:0];
        REG_OVERLAP:     overlap_r     <= cfg_s.data[OVL_W-1:0];
        REG_NUM_OUTPUTS: num_outputs_r <= cfg_s.data[NOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_width_r == '0) begin
      width_eff = IN_W_W'(1);
    end else if (in_width_r > IN_W_W'(COLUMN_LIMIT)) begin
      width_eff = IN_W_W'(COLUMN_LIMIT);
    end else begin
      width_eff = in_width_r;
    end
    if (num_outputs_r == '0) begin
      count_eff = NOUT_W'(1);
    end else if (num_outputs_r > NOUT_W'(MAX_OUTPUTS)) begin
      count_eff = NOUT_W'(MAX_OUTPUTS);
    end else begin
      count_eff = num_outputs_r;
    end
  end

  assign owid   = $signed({{(POS_W-OUT_W_W){1'b0}}, out_width_r});
  assign stride = owid - $signed({{(POS_W-OVL_W){overlap_r[OVL_W-1]}}, overlap_r});
  assign col_s  = $signed({{(POS_W-COL_W){1'b0}}, column_r});

  // window k spans [k*stride, k*stride + out_width)
  for (genvar k = 0; k < MAX_OUTPUTS; k++) begin : g_win
    logic signed [POS_W-1:0] w_start;
    logic signed [POS_W-1:0] w_stop;
    assign w_start  = stride * $signed(POS_W'(k));
    assign w_stop   = w_start + owid;
    assign covered[k] = (NOUT_W'(k) < count_eff) && (col_s >= w_start) && (col_s < w_stop);
    assign at_end[k] = (col_s == w_stop - POS_W'(1));
  end

  // first two covering windows, lower port first
  always_comb begin
    route = '0;
    got_a = 1'b0;
    for (int k = 0; k < MAX_OUTPUTS; k++) begin
      if (covered[k] && !route.two) begin
        if (!got_a) begin
          route.port_a = PORT_W'(k);
          route.end_a  = at_end[k];
          got_a        = 1'b1;
        end else begin
          route.port_b = PORT_W'(k);
          route.end_b  = at_end[k];
          route.two    = 1'b1;
        end
      end
    end
  end

  // uncovered columns are dropped here and never reach the queue
  assign push      = accept && got_a;
  assign push_data = {in_s.data_in, route};

  always_comb begin
    col_inc    = {2'b00, column_r} + 1'b1;
    column_nxt = (col_inc >= {1'b0, width_eff}) ? '0 : col_inc[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else if (accept) begin
      column_r <= column_nxt;
    end
  end

`ifndef SYNTH
  a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (column_r == '0) || (column_r == $past(column_r) + 1'b1))
    else $error("column counter neither stepped nor wrapped");
`endif

endmodule

>>> rtl/owss_back.sv
module owss_back import owss_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  logic [DATA_WIDTH+$bits(route_t)-1:0] q_head,
  output logic                                 pop,
  owss_out_if.source                           out_m
);

  logic                  out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0]     out_port_r, out_port_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                  out_end_r, out_end_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  phase_r, phase_nxt;

  route_t                route;
  logic [DATA_WIDTH-1:0] head_data;
  logic                  load;

  assign route     = q_head[$bits(route_t)-1:0];
  assign head_data = q_head[DATA_WIDTH+$bits(route_t)-1:$bits(route_t)];
  assign load      = !q_empty && (!out_valid_r || out_m.ready);

  // phase_r set: first word of a shared element is out, second one next
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_port_nxt  = out_port_r;
    out_data_nxt  = out_data_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = head_data;
      if (!phase_r) begin
        out_port_nxt = route.port_a;
        out_end_nxt  = route.end_a;
        out_last_nxt = !route.two;
        phase_nxt    = route.two;
        pop          = !route.two;
      end else begin
        out_port_nxt = route.port_b;
        out_end_nxt  = route.end_b;
        out_last_nxt = 1'b1;
        phase_nxt    = 1'b0;
        pop          = 1'b1;
      end
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_port_r <= out_port_nxt;
    out_data_r <= out_data_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.port       = out_port_r;
  assign out_m.data_out   = out_data_r;
  assign out_m.window_end = out_end_r;
  assign out_m.last       = out_last_r;

`ifndef SYNTH
  a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_empty && out_valid_r && !out_last_r))
    else $error("second word pending without its queue entry");
`endif

endmodule

>>> rtl/overlapping_window_stream_split.sv
// Overlapping window splitter: each input word is one element of a row of in_width columns
// and is copied to every window (up to MAX_OUTPUTS, out_width wide, window k starting at
// column k*(out_width-overlap)) that covers its column, at most two, lower port first;
// uncovered columns are dropped and the column counter wraps at in_width. A word is taken
// every cycle while the four-entry queue between the classifier and the output stage has
// room; the output register issues one result word per cycle while the sink is ready, so
// an element in a shared band takes two result words and a dropped element none. Registers
// are written through the cfg channel (0 in_width, 1 out_width, 2 overlap, 3 num_outputs);
// the user must write them only while the block is idle; the block does not enforce it.
module overlapping_window_stream_split import owss_pkg::*; #(
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic         clk,
  input  logic         rst_n,
  owss_in_if.sink      in_s,
  owss_out_if.source   out_m,
  owss_cfg_if.sink     cfg_s
);

  localparam int QW = DATA_WIDTH + $bits(route_t);

  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic [QW-1:0] q_head;
  logic          q_full;
  logic          q_empty;

  owss_front #(
    .DATA_WIDTH  (DATA_WIDTH),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .cfg_s     (cfg_s),
    .push      (push),
    .push_data (push_data),
    .full      (q_full)
  );

  owss_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  owss_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .out_m   (out_m)
  );

endmodule
